// ===== rtl/core/clm_pkg.sv =====
// Shared types and constants of the CPU load monitor.
package clm_pkg;

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned LOAD_W    = 10;
  localparam int unsigned QUOT_W    = 12;
  localparam int unsigned PERMILLE  = 1000;
  localparam int unsigned CALC_PERIOD_RESET = 1000;

  typedef enum logic [FUNC_W-1:0] {
    FN_SWITCH = 2'd0,
    FN_IRQ_ENTER = 2'd1,
    FN_IRQ_EXIT = 2'd2,
    FN_TICK = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNT_DOWN = 2'd0,
    REG_RELOAD = 2'd1,
    REG_EXPIRE = 2'd2,
    REG_CALC_PERIOD = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVENT,
    S_ACCUM,
    S_TOTAL,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/clm_if.sv =====
// Valid/ready channel interfaces for the event items and the load result items.
interface clm_in_if;
  import clm_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [SAMPLE_W-1:0] timer_sample;
  logic                running_idle;

  modport source (output valid, output func, output timer_sample, output running_idle,
                  input ready);
  modport sink (input valid, input func, input timer_sample, input running_idle,
                output ready);
endinterface

interface clm_out_if;
  import clm_pkg::*;
  logic              valid;
  logic              ready;
  logic [LOAD_W-1:0] total_load;
  logic [LOAD_W-1:0] interrupt_load;

  modport source (output valid, output total_load, output interrupt_load, input ready);
  modport sink (input valid, input total_load, input interrupt_load, output ready);
endinterface

// ===== rtl/core/cpu_load_monitor.sv =====
// CPU load monitor top level: tick buckets, event sequencer and shared divider.
// Each accepted item is worked on alone while in_ch.ready is low. A context switch
// or interrupt entry/exit passes through S_EVENT and S_ACCUM, and a calculation
// tick that does not expire through S_EVENT alone. An expiring tick is decoded
// in S_EVENT and the bucket sums are formed in S_TOTAL; the shared restoring
// divider then runs twice, each run an S_MUL multiply and 12 quotient steps in
// S_DIV, and S_DONE loads the result register once that register is free.
// The result waits in an output register while new items are accepted; a later
// result waits in S_DONE until that register is taken.
module cpu_load_monitor #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned NEST_WIDTH  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [clm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clm_pkg::CFG_W-1:0]     cfg_wdata,
  clm_in_if.sink                        in_ch,
  clm_out_if.source                     out_ch
);
  import clm_pkg::*;

  localparam int unsigned NUM_W  = COUNT_WIDTH + LOAD_W;
  localparam int unsigned DVS_W  = COUNT_WIDTH + QUOT_W;
  localparam int unsigned STEP_W = $clog2(QUOT_W);

  state_t state_r, state_nxt;

  logic                   count_down_r;
  logic [COUNT_WIDTH-1:0] reload_r;
  logic [COUNT_WIDTH-1:0] expire_r;
  logic [TICK_W-1:0]      period_r;

  logic [COUNT_WIDTH-1:0] last_r, last_nxt;
  logic [COUNT_WIDTH-1:0] busy_r, busy_nxt;
  logic [COUNT_WIDTH-1:0] irq_r, irq_nxt;
  logic [COUNT_WIDTH-1:0] idle_r, idle_nxt;
  logic [NEST_WIDTH-1:0]  nest_r, nest_nxt;
  logic [TICK_W-1:0]      ticks_r, ticks_nxt;

  func_t                  func_r, func_nxt;
  logic [COUNT_WIDTH-1:0] sample_r, sample_nxt;
  logic                   run_idle_r, run_idle_nxt;
  logic [COUNT_WIDTH-1:0] dist_r, dist_nxt;

  logic [COUNT_WIDTH-1:0] total_r, total_nxt;
  logic [COUNT_WIDTH-1:0] part_r, part_nxt;
  logic [NUM_W-1:0]       rem_r, rem_nxt;
  logic [QUOT_W-1:0]      quot_r, quot_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic                   second_r, second_nxt;
  logic [LOAD_W-1:0]      ld_total_r, ld_total_nxt;
  logic [LOAD_W-1:0]      ld_irq_r, ld_irq_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [LOAD_W-1:0]      out_total_r, out_total_nxt;
  logic [LOAD_W-1:0]      out_irq_r, out_irq_nxt;

  logic [COUNT_WIDTH-1:0] elapsed;
  logic [COUNT_WIDTH-1:0] bucket_sum;
  logic [DVS_W-1:0]       dvs;
  logic                   fits;
  logic [QUOT_W-1:0]      quot_done;
  logic [LOAD_W-1:0]      share;
  logic                   to_irq;
  logic                   out_free;

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.total_load     = out_total_r;
  assign out_ch.interrupt_load = out_irq_r;
  assign out_free              = !out_valid_r || out_ch.ready;

  always_comb begin
    if (count_down_r) begin
      if (last_r >= sample_r) begin
        elapsed = last_r - sample_r;
      end else begin
        elapsed = last_r + (reload_r - sample_r);
      end
    end else begin
      if (last_r <= sample_r) begin
        elapsed = sample_r - last_r;
      end else begin
        elapsed = sample_r + (expire_r - last_r);
      end
    end
  end

  // Divider step: compare the remainder with the divisor shifted by the step index.
  assign dvs  = DVS_W'(total_r) << step_r;
  assign fits = (DVS_W'(rem_r) >= dvs);

  always_comb begin
    quot_done         = quot_r;
    quot_done[step_r] = fits;
    if (total_r == '0) begin
      share = '0;
    end else if (quot_done > QUOT_W'(PERMILLE)) begin
      share = LOAD_W'(PERMILLE);
    end else begin
      share = quot_done[LOAD_W-1:0];
    end
  end

  assign to_irq = (func_r == FN_IRQ_EXIT) ||
                  ((func_r == FN_IRQ_ENTER) && (nest_r > NEST_WIDTH'(1)));

  always_comb begin
    if (to_irq) begin
      bucket_sum = irq_r + dist_r;
    end else if (run_idle_r) begin
      bucket_sum = idle_r + dist_r;
    end else begin
      bucket_sum = busy_r + dist_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    busy_nxt      = busy_r;
    irq_nxt       = irq_r;
    idle_nxt      = idle_r;
    nest_nxt      = nest_r;
    ticks_nxt     = ticks_r;
    func_nxt      = func_r;
    sample_nxt    = sample_r;
    run_idle_nxt  = run_idle_r;
    dist_nxt      = dist_r;
    total_nxt     = total_r;
    part_nxt      = part_r;
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    step_nxt      = step_r;
    second_nxt    = second_r;
    ld_total_nxt  = ld_total_r;
    ld_irq_nxt    = ld_irq_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_total_nxt = out_total_r;
    out_irq_nxt   = out_irq_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt     = func_t'(in_ch.func);
          sample_nxt   = in_ch.timer_sample[COUNT_WIDTH-1:0];
          run_idle_nxt = in_ch.running_idle;
          state_nxt    = S_EVENT;
        end
      end
      S_EVENT: begin
        if (func_r == FN_TICK) begin
          ticks_nxt = ticks_r - TICK_W'(1);
          state_nxt = (ticks_r == TICK_W'(1)) ? S_TOTAL : S_IDLE;
        end else begin
          dist_nxt = elapsed;
          if (func_r == FN_IRQ_ENTER) begin
            nest_nxt = nest_r + NEST_WIDTH'(1);
          end else if (func_r == FN_IRQ_EXIT) begin
            nest_nxt = nest_r - NEST_WIDTH'(1);
          end
          state_nxt = S_ACCUM;
        end
      end
      S_ACCUM: begin
        if (to_irq) begin
          irq_nxt = bucket_sum;
        end else if (run_idle_r) begin
          idle_nxt = bucket_sum;
        end else begin
          busy_nxt = bucket_sum;
        end
        last_nxt  = sample_r;
        state_nxt = S_IDLE;
      end
      S_TOTAL: begin
        total_nxt  = busy_r + irq_r + idle_r;
        part_nxt   = busy_r + irq_r;
        second_nxt = 1'b0;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        rem_nxt   = NUM_W'(part_r) * NUM_W'(PERMILLE);
        quot_nxt  = '0;
        step_nxt  = STEP_W'(QUOT_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (fits) begin
          rem_nxt = rem_r - dvs[NUM_W-1:0];
        end
        quot_nxt = quot_done;
        if (step_r == '0) begin
          if (!second_r) begin
            ld_total_nxt = share;
            part_nxt     = irq_r;
            second_nxt   = 1'b1;
            state_nxt    = S_MUL;
          end else begin
            ld_irq_nxt = share;
            state_nxt  = S_DONE;
          end
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = ld_total_r;
          out_irq_nxt   = ld_irq_r;
          busy_nxt      = COUNT_WIDTH'(1);
          irq_nxt       = '0;
          idle_nxt      = '0;
          ticks_nxt     = period_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_down_r <= 1'b1;
      reload_r     <= '1;
      expire_r     <= '1;
      period_r     <= TICK_W'(CALC_PERIOD_RESET);
      last_r       <= '0;
      busy_r       <= COUNT_WIDTH'(1);
      irq_r        <= '0;
      idle_r       <= '0;
      nest_r       <= '0;
      ticks_r      <= TICK_W'(CALC_PERIOD_RESET);
      second_r     <= 1'b0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      busy_r      <= busy_nxt;
      irq_r       <= irq_nxt;
      idle_r      <= idle_nxt;
      nest_r      <= nest_nxt;
      ticks_r     <= ticks_nxt;
      second_r    <= second_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_COUNT_DOWN:  count_down_r <= cfg_wdata[0];
          REG_RELOAD:      reload_r     <= cfg_wdata[COUNT_WIDTH-1:0];
          REG_EXPIRE:      expire_r     <= cfg_wdata[COUNT_WIDTH-1:0];
          REG_CALC_PERIOD: period_r     <= cfg_wdata[TICK_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    sample_r    <= sample_nxt;
    run_idle_r  <= run_idle_nxt;
    dist_r      <= dist_nxt;
    total_r     <= total_nxt;
    part_r      <= part_nxt;
    rem_r       <= rem_nxt;
    quot_r      <= quot_nxt;
    ld_total_r  <= ld_total_nxt;
    ld_irq_r    <= ld_irq_nxt;
    out_total_r <= out_total_nxt;
    out_irq_r   <= out_irq_nxt;
  end

`ifndef NO_ASSERTIONS
  a_event_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.func != FN_TICK)) |-> ##3 (state_r == S_IDLE))
    else $error("Event item did not finish in three cycles.");

  a_bucket_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && out_free) |=>
      ((busy_r == COUNT_WIDTH'(1)) && (irq_r == '0) && (idle_r == '0) && out_valid_r))
    else $error("Buckets not restarted with the result.");

  a_nest_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EVENT) |=> $stable(nest_r))
    else $error("Nesting depth changed outside event processing.");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for cpu_load_monitor with a load-prediction scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import clm_pkg::*;

  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 115;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic [LOAD_W-1:0] total;
    logic [LOAD_W-1:0] irq;
  } load_t;

  class load_scoreboard;
    bit                count_down;
    bit [TICK_W-1:0]   reload_value;
    bit [TICK_W-1:0]   expire_value;
    bit [TICK_W-1:0]   calc_period;
    bit [SAMPLE_W-1:0] last_sample;
    bit [TICK_W-1:0]   busy_ticks;
    bit [TICK_W-1:0]   irq_ticks;
    bit [TICK_W-1:0]   idle_ticks;
    bit [TICK_W-1:0]   ticks_left;
    bit [7:0]          nest_depth;
    load_t             pending_loads[$];
    int                failures;
    int                results_seen;

    function new();
      count_down   = 1'b1;
      reload_value = '1;
      expire_value = '1;
      calc_period  = CALC_PERIOD_RESET;
      last_sample  = '0;
      busy_ticks   = 1;
      irq_ticks    = '0;
      idle_ticks   = '0;
      nest_depth   = '0;
      ticks_left   = CALC_PERIOD_RESET;
    endfunction

    function void write_reg(reg_idx_t idx, bit [CFG_W-1:0] val);
      case (idx)
        REG_COUNT_DOWN: count_down = val[0];
        REG_RELOAD: reload_value = val;
        REG_EXPIRE: expire_value = val;
        REG_CALC_PERIOD: calc_period = val;
        default: ;
      endcase
    endfunction

    function bit [LOAD_W-1:0] permille(bit [TICK_W-1:0] part, bit [TICK_W-1:0] whole);
      bit [63:0] q;
      if (whole == 0) return '0;
      q = ({32'd0, part} * 64'(PERMILLE)) / {32'd0, whole};
      return (q > PERMILLE) ? LOAD_W'(PERMILLE) : q[LOAD_W-1:0];
    endfunction

    function void note_event(func_t fn, bit [SAMPLE_W-1:0] smp, bit idl);
      bit [TICK_W-1:0] gap_ticks;
      bit [TICK_W-1:0] busy_irq;
      load_t r;
      if (fn == FN_TICK) begin
        ticks_left = ticks_left - 1;
        if (ticks_left == 0) begin
          busy_irq = busy_ticks + irq_ticks;
          r.total = permille(busy_irq, busy_irq + idle_ticks);
          r.irq = permille(irq_ticks, busy_irq + idle_ticks);
          pending_loads.push_back(r);
          busy_ticks = 1;
          irq_ticks  = '0;
          idle_ticks = '0;
          ticks_left = calc_period;
        end
        return;
      end
      if (count_down) begin
        gap_ticks = (last_sample >= smp) ? last_sample - smp
                                         : last_sample + (reload_value - smp);
      end else begin
        gap_ticks = (last_sample <= smp) ? smp - last_sample
                                         : smp + (expire_value - last_sample);
      end
      case (fn)
        FN_SWITCH: begin
          if (idl) idle_ticks += gap_ticks;
          else busy_ticks += gap_ticks;
        end
        FN_IRQ_ENTER: begin
          nest_depth = nest_depth + 8'd1;
          if (nest_depth > 1) irq_ticks += gap_ticks;
          else if (idl) idle_ticks += gap_ticks;
          else busy_ticks += gap_ticks;
        end
        default: begin
          nest_depth = nest_depth - 8'd1;
          irq_ticks += gap_ticks;
        end
      endcase
      last_sample = smp;
    endfunction

    function void check_load(bit [LOAD_W-1:0] total, bit [LOAD_W-1:0] irq);
      load_t want;
      results_seen++;
      if (pending_loads.size() == 0) begin
        $error("load result %0d/%0d arrived with no expected item", total, irq);
        failures++;
        return;
      end
      want = pending_loads.pop_front();
      if (total !== want.total) begin
        $error("total_load expected %0d actual %0d", want.total, total);
        failures++;
      end
      if (irq !== want.irq) begin
        $error("interrupt_load expected %0d actual %0d", want.irq, irq);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  clm_in_if  in_ch();
  clm_out_if out_ch();

  load_scoreboard sb = new();
  int burst_left = 0;

  cpu_load_monitor DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #4 clk = ~clk;

  task automatic send_item(func_t fn, bit [SAMPLE_W-1:0] smp, bit idl);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.func         <= fn;
    in_ch.timer_sample <= smp;
    in_ch.running_idle <= idl;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_event(fn, smp, idl);
  endtask

  task automatic write_reg(reg_idx_t idx, bit [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending_loads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic bit [CFG_W-1:0] pick_limit();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return $urandom_range(1, 5000);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_load(out_ch.total_load, out_ch.interrupt_load);
    end
  end

  initial begin
    int stretch_left;
    int stall_mode;
    bit long_hold_done;
    stretch_left = 0;
    stall_mode = 0;
    long_hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && sb.results_seen >= 12) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(8, 64);
        stall_mode = $urandom_range(0, 2);
      end
      stretch_left--;
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    bit cd;
    bit [CFG_W-1:0] rl;
    bit [CFG_W-1:0] ex;
    bit [CFG_W-1:0] per;
    bit [SAMPLE_W-1:0] tmr;
    bit [SAMPLE_W-1:0] step;
    bit [SAMPLE_W-1:0] smp;
    func_t fn;
    int sel;
    int count;
    in_ch.valid = 1'b0;
    in_ch.func = FN_SWITCH;
    in_ch.timer_sample = '0;
    in_ch.running_idle = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_COUNT_DOWN;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The period write only takes effect at the first expiry, which still
    // needs the full reset countdown.
    write_reg(REG_CALC_PERIOD, 1);
    send_item(FN_SWITCH, 32'h0000_0000, 1'b0);
    send_item(FN_SWITCH, 32'hFFFF_FFFF, 1'b0);
    send_item(FN_SWITCH, 32'h0000_1000, 1'b1);
    send_item(FN_IRQ_ENTER, 32'h0000_0800, 1'b1);
    send_item(FN_IRQ_ENTER, 32'h0000_0400, 1'b0);
    send_item(FN_IRQ_EXIT, 32'h0000_0200, 1'b0);
    send_item(FN_IRQ_EXIT, 32'h0000_0100, 1'b1);
    // Exit at depth zero wraps the nesting; the next entry wraps back.
    send_item(FN_IRQ_EXIT, 32'h0000_0080, 1'b0);
    send_item(FN_IRQ_ENTER, 32'h0000_0040, 1'b0);
    send_item(FN_IRQ_ENTER, 32'h0000_0020, 1'b1);
    send_item(FN_IRQ_EXIT, 32'h0000_0010, 1'b1);
    send_item(FN_TICK, 32'hFFFF_FFFF, 1'b1);
    send_item(FN_SWITCH, 32'hAAAA_AAAA, 1'b0);
    send_item(FN_SWITCH, 32'h5555_5555, 1'b1);
    while (sb.ticks_left > 1) send_item(FN_TICK, $urandom, 1'($urandom_range(0, 1)));
    send_item(FN_TICK, 32'h0, 1'b0);

    // With a period of one, every tick expires. After one plain result, a total
    // wraps to zero, then an idle count wraps the total below the busy share.
    send_item(FN_SWITCH, 32'hFFFF_FFFF, 1'b1);
    send_item(FN_TICK, 32'h0, 1'b0);
    send_item(FN_SWITCH, 32'h0000_0000, 1'b0);
    send_item(FN_TICK, 32'h0, 1'b0);
    send_item(FN_SWITCH, 32'h8000_0001, 1'b0);
    send_item(FN_SWITCH, 32'hFFFF_FFF0, 1'b1);
    send_item(FN_TICK, 32'h0, 1'b0);

    tmr = $urandom;
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      cd  = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      rl  = (p == 0) ? '1 : (p == 1) ? '0 : pick_limit();
      ex  = (p == 0) ? '0 : (p == 1) ? '1 : pick_limit();
      per = (p == NUM_PHASES - 1) ? '1 : $urandom_range(1, 6);
      write_reg(REG_COUNT_DOWN, ($urandom & 32'hFFFF_FFFE) | cd);
      write_reg(REG_RELOAD, rl);
      write_reg(REG_EXPIRE, ex);
      write_reg(REG_CALC_PERIOD, per);
      count = (p == NUM_PHASES - 1) ? 45 : PHASE_ITEMS;
      for (int i = 0; i < count; i++) begin
        sel = $urandom_range(0, 9);
        if (sel < 3) fn = FN_SWITCH;
        else if (sel < 5) fn = FN_IRQ_ENTER;
        else if (sel < 7) fn = FN_IRQ_EXIT;
        else fn = FN_TICK;
        if (fn == FN_IRQ_EXIT && sb.nest_depth == 0 && $urandom_range(0, 7) != 0) begin
          fn = FN_SWITCH;
        end
        if (fn == FN_IRQ_ENTER && sb.nest_depth >= 4) fn = FN_IRQ_EXIT;
        sel = $urandom_range(0, 19);
        if (sel < 13) begin
          step = (sel == 0) ? $urandom : $urandom_range(0, 3000);
          if (cd) tmr = (tmr >= step) ? tmr - step : rl - (step - tmr);
          else tmr = (ex - tmr >= step) ? tmr + step : step - (ex - tmr);
          smp = tmr;
        end else if (sel < 17) begin
          smp = $urandom;
        end else if (sel == 17) begin
          smp = '0;
        end else if (sel == 18) begin
          smp = '1;
        end else begin
          smp = cd ? rl : ex;
        end
        send_item(fn, smp, 1'($urandom_range(0, 1)));
      end
    end
    drain();
    repeat (40) @(posedge clk);
    if (sb.failures == 0 && sb.pending_loads.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
